// ===== rtl/chained_pose_reprojection_residual_assert.svh =====
// assertion macros used by the checker file
// no dependencies; included by file name
`ifndef CHAINED_POSE_REPROJECTION_RESIDUAL_ASSERT_SVH
`define CHAINED_POSE_REPROJECTION_RESIDUAL_ASSERT_SVH

// same-cycle implication
`define CPRR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CPRR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/cprr_pkg.sv =====
// types, constants, saturation and sign-extension helpers for the reprojection residual block
// no dependencies
`default_nettype none

package cprr_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_INTRINSICS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAM_ROT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAM_TRANS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BRD_ROT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BRD_TRANS  = 3'd4;

    localparam logic [63:0] ROT_RESET = 64'd16384;
    localparam int          QUO_W     = 22;

    typedef logic signed [15:0] t_qc;
    typedef logic signed [31:0] t_pt;

    function automatic t_qc clamp_q(input logic signed [15:0] v);
        t_qc r;
        if (v > 16'sd16384) begin
            r = 16'sd16384;
        end else if (v < -16'sd16384) begin
            r = -16'sd16384;
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic t_pt sat32(input logic signed [37:0] v);
        t_pt r;
        if (v > 38'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -38'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic t_pt sext20(input logic [19:0] v);
        return {{12{v[19]}}, v};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/cprr_if.sv =====
// request and result channel interfaces for the reprojection residual block
// no dependencies
`default_nettype none

interface cprr_req_if;
    logic               valid;
    logic               ready;
    logic signed [19:0] obj_x;
    logic signed [19:0] obj_y;
    logic signed [19:0] obj_z;
    logic        [15:0] pix_u;
    logic        [15:0] pix_v;
    logic signed [15:0] body_qw;
    logic signed [15:0] body_qx;
    logic signed [15:0] body_qy;
    logic signed [15:0] body_qz;
    logic signed [19:0] body_tx;
    logic signed [19:0] body_ty;
    logic signed [19:0] body_tz;

    modport source (output valid, obj_x, obj_y, obj_z, pix_u, pix_v, body_qw, body_qx,
                    body_qy, body_qz, body_tx, body_ty, body_tz, input ready);
    modport sink (input valid, obj_x, obj_y, obj_z, pix_u, pix_v, body_qw, body_qx,
                  body_qy, body_qz, body_tx, body_ty, body_tz, output ready);
endinterface

interface cprr_res_if;
    logic               valid;
    logic               ready;
    logic signed [19:0] residual_u;
    logic signed [19:0] residual_v;
    logic               depth_fault;

    modport source (output valid, residual_u, residual_v, depth_fault, input ready);
    modport sink (input valid, residual_u, residual_v, depth_fault, output ready);
endinterface

`default_nettype wire

// ===== rtl/cprr_rot.sv =====
// five-stage rotate-and-translate pipeline for one quaternion pose
// depends on cprr_pkg
`default_nettype none

module cprr_rot (
    input  logic           i_clk,
    input  logic           i_en,
    input  cprr_pkg::t_qc  i_q [4],
    input  cprr_pkg::t_pt  i_p [3],
    input  cprr_pkg::t_pt  i_t [3],
    output cprr_pkg::t_pt  o_r [3]
);
    import cprr_pkg::*;

    localparam int WX = 0;
    localparam int WY = 1;
    localparam int WZ = 2;
    localparam int XX = 3;
    localparam int XY = 4;
    localparam int XZ = 5;
    localparam int YY = 6;
    localparam int YZ = 7;
    localparam int ZZ = 8;

    logic signed [29:0] r_a_prod [9];
    t_pt                r_a_p [3];
    t_pt                r_a_t [3];
    logic signed [30:0] n_b_m [9];
    logic signed [30:0] r_b_m [9];
    t_pt                r_b_p [3];
    t_pt                r_b_t [3];
    logic signed [62:0] r_c_mp [9];
    t_pt                r_c_p [3];
    t_pt                r_c_t [3];
    logic signed [62:0] r_d_s [3];
    t_pt                r_d_p [3];
    t_pt                r_d_t [3];
    t_pt                n_e_r [3];
    t_pt                r_e_r [3];
    logic signed [30:0] w_e [9];
    logic signed [62:0] w_rnd [3];
    logic signed [62:0] w_sh [3];
    logic signed [37:0] w_tot [3];

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            w_e[k] = {r_a_prod[k][29], r_a_prod[k]};
        end
        n_b_m[0] = -(w_e[YY] + w_e[ZZ]);
        n_b_m[1] = w_e[XY] - w_e[WZ];
        n_b_m[2] = w_e[WY] + w_e[XZ];
        n_b_m[3] = w_e[WZ] + w_e[XY];
        n_b_m[4] = -(w_e[XX] + w_e[ZZ]);
        n_b_m[5] = w_e[YZ] - w_e[WX];
        n_b_m[6] = w_e[XZ] - w_e[WY];
        n_b_m[7] = w_e[WX] + w_e[YZ];
        n_b_m[8] = -(w_e[XX] + w_e[YY]);
        for (int r = 0; r < 3; r++) begin
            w_rnd[r] = r_d_s[r] + 63'sd67108864;
            w_sh[r]  = w_rnd[r] >>> 27;
            w_tot[r] = {{2{w_sh[r][35]}}, w_sh[r][35:0]}
                     + {{6{r_d_p[r][31]}}, r_d_p[r]}
                     + {{6{r_d_t[r][31]}}, r_d_t[r]};
            n_e_r[r] = sat32(w_tot[r]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_prod[WX] <= 30'(i_q[0] * i_q[1]);
            r_a_prod[WY] <= 30'(i_q[0] * i_q[2]);
            r_a_prod[WZ] <= 30'(i_q[0] * i_q[3]);
            r_a_prod[XX] <= 30'(i_q[1] * i_q[1]);
            r_a_prod[XY] <= 30'(i_q[1] * i_q[2]);
            r_a_prod[XZ] <= 30'(i_q[1] * i_q[3]);
            r_a_prod[YY] <= 30'(i_q[2] * i_q[2]);
            r_a_prod[YZ] <= 30'(i_q[2] * i_q[3]);
            r_a_prod[ZZ] <= 30'(i_q[3] * i_q[3]);
            for (int k = 0; k < 9; k++) begin
                r_b_m[k] <= n_b_m[k];
            end
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_c_mp[3*r+c] <= 63'(r_b_m[3*r+c]) * 63'(r_b_p[c]);
                end
                r_d_s[r] <= r_c_mp[3*r] + r_c_mp[3*r+1] + r_c_mp[3*r+2];
                r_a_p[r] <= i_p[r];
                r_a_t[r] <= i_t[r];
                r_b_p[r] <= r_a_p[r];
                r_b_t[r] <= r_a_t[r];
                r_c_p[r] <= r_b_p[r];
                r_c_t[r] <= r_b_t[r];
                r_d_p[r] <= r_c_p[r];
                r_d_t[r] <= r_c_t[r];
                r_e_r[r] <= n_e_r[r];
            end
        end
    end

    assign o_r = r_e_r;

endmodule

`default_nettype wire

// ===== rtl/chained_pose_reprojection_residual.sv =====
// throughput: one request per cycle; a stalled result freezes every stage
// the divider is 22 single-bit restoring steps, one per stage
// reset (synchronous, active low) empties the pipeline and restores the configuration registers
// depends on cprr_pkg, cprr_req_if, cprr_res_if, cprr_rot
`default_nettype none

module chained_pose_reprojection_residual (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [cprr_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [cprr_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    cprr_req_if.sink                           i_req,
    cprr_res_if.source                         o_res
);
    import cprr_pkg::*;

    localparam int LAT  = 42;
    localparam int NDIV = QUO_W + 1;

    typedef struct packed {
        logic neg_u;
        logic neg_v;
        logic ovf_u;
        logic ovf_v;
        logic fault;
    } t_side;

    logic [63:0] r_intr;
    logic [63:0] r_cam_q;
    logic [59:0] r_cam_t;
    logic [63:0] r_brd_q;
    logic [59:0] r_brd_t;

    logic        r_v [LAT+1];
    logic        w_adv;

    t_qc         w_brd_q [4];
    t_qc         w_cam_q [4];
    t_pt         w_brd_t [3];
    t_pt         w_cam_t [3];
    t_pt         w_zero [3];

    t_pt         r_s0_p [3];
    t_qc         r_qn [7][4];
    logic [19:0] r_tn [6][3];
    logic [15:0] r_pu [LAT];
    logic [15:0] r_pv [LAT];

    t_pt         w_pw [3];
    t_pt         r_s6_d [3];
    t_pt         w_pb [3];
    t_pt         w_pc [3];

    logic signed [48:0] r_s17_nx;
    logic signed [48:0] r_s17_ny;
    t_pt                r_s17_z;
    logic               r_s17_flt;

    logic [48:0] r_s18_nu;
    logic [48:0] r_s18_nv;
    logic [32:0] r_s18_d;
    t_side       r_s18_sd;
    logic [47:0] w_mag_u;
    logic [47:0] w_mag_v;

    logic [32:0]      r_rem_u [NDIV];
    logic [32:0]      r_rem_v [NDIV];
    logic [QUO_W-1:0] r_low_u [NDIV];
    logic [QUO_W-1:0] r_low_v [NDIV];
    logic [QUO_W-1:0] r_quo_u [NDIV];
    logic [QUO_W-1:0] r_quo_v [NDIV];
    logic [32:0]      r_dd [NDIV];
    t_side            r_sd [NDIV];
    logic [33:0]      w_sh_u [NDIV];
    logic [33:0]      w_sh_v [NDIV];
    logic             w_ge_u [NDIV];
    logic             w_ge_v [NDIV];
    t_side            w_sd0;

    logic [QUO_W-1:0]   w_qq_u;
    logic [QUO_W-1:0]   w_qq_v;
    logic signed [25:0] w_ru;
    logic signed [25:0] w_rv;
    logic signed [19:0] n_out_u;
    logic signed [19:0] n_out_v;
    logic signed [19:0] r_out_u;
    logic signed [19:0] r_out_v;
    logic               r_out_f;

    assign w_adv       = !r_v[LAT] || o_res.ready;
    assign i_req.ready = w_adv;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_intr  <= '0;
            r_cam_q <= ROT_RESET;
            r_cam_t <= '0;
            r_brd_q <= ROT_RESET;
            r_brd_t <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_INTRINSICS: r_intr  <= i_cfg_data;
                CFG_CAM_ROT:    r_cam_q <= i_cfg_data;
                CFG_CAM_TRANS:  r_cam_t <= i_cfg_data[59:0];
                CFG_BRD_ROT:    r_brd_q <= i_cfg_data;
                CFG_BRD_TRANS:  r_brd_t <= i_cfg_data[59:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_brd_q[i] = clamp_q(r_brd_q[16*i +: 16]);
            w_cam_q[i] = clamp_q(r_cam_q[16*i +: 16]);
        end
        for (int i = 0; i < 3; i++) begin
            w_brd_t[i] = sext20(r_brd_t[20*i +: 20]);
            w_cam_t[i] = sext20(r_cam_t[20*i +: 20]);
            w_zero[i]  = '0;
        end
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= LAT; k++) begin
                r_v[k] <= 1'b0;
            end
        end else if (w_adv) begin
            r_v[0] <= i_req.valid;
            for (int k = 1; k <= LAT; k++) begin
                r_v[k] <= r_v[k-1];
            end
        end
    end

    // request capture and side delay lines
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s0_p[0] <= sext20(i_req.obj_x);
            r_s0_p[1] <= sext20(i_req.obj_y);
            r_s0_p[2] <= sext20(i_req.obj_z);
            r_qn[0][0] <= clamp_q(i_req.body_qw);
            r_qn[0][1] <= -clamp_q(i_req.body_qx);
            r_qn[0][2] <= -clamp_q(i_req.body_qy);
            r_qn[0][3] <= -clamp_q(i_req.body_qz);
            r_tn[0][0] <= i_req.body_tx;
            r_tn[0][1] <= i_req.body_ty;
            r_tn[0][2] <= i_req.body_tz;
            r_pu[0] <= i_req.pix_u;
            r_pv[0] <= i_req.pix_v;
            for (int k = 1; k < 7; k++) begin
                r_qn[k] <= r_qn[k-1];
            end
            for (int k = 1; k < 6; k++) begin
                r_tn[k] <= r_tn[k-1];
            end
            for (int k = 1; k < LAT; k++) begin
                r_pu[k] <= r_pu[k-1];
                r_pv[k] <= r_pv[k-1];
            end
        end
    end

    // board to world
    cprr_rot u_rot_brd (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_q   (w_brd_q),
        .i_p   (r_s0_p),
        .i_t   (w_brd_t),
        .o_r   (w_pw)
    );

    // subtract body translation
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int i = 0; i < 3; i++) begin
                r_s6_d[i] <= sat32({{6{w_pw[i][31]}}, w_pw[i]}
                                 - {{18{r_tn[5][i][19]}}, r_tn[5][i]});
            end
        end
    end

    // world to body
    cprr_rot u_rot_body (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_q   (r_qn[6]),
        .i_p   (r_s6_d),
        .i_t   (w_zero),
        .o_r   (w_pb)
    );

    // body to camera
    cprr_rot u_rot_cam (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_q   (w_cam_q),
        .i_p   (w_pb),
        .i_t   (w_cam_t),
        .o_r   (w_pc)
    );

    // focal products, numerators and divisor
    assign w_mag_u = r_s17_nx[48] ? 48'(-r_s17_nx) : r_s17_nx[47:0];
    assign w_mag_v = r_s17_ny[48] ? 48'(-r_s17_ny) : r_s17_ny[47:0];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s17_nx  <= 49'($signed({1'b0, r_intr[15:0]})) * 49'(w_pc[0]);
            r_s17_ny  <= 49'($signed({1'b0, r_intr[31:16]})) * 49'(w_pc[1]);
            r_s17_z   <= w_pc[2];
            r_s17_flt <= (w_pc[2] <= 32'sd0);

            r_s18_nu       <= {w_mag_u, 1'b0} + {18'b0, r_s17_z[30:0]};
            r_s18_nv       <= {w_mag_v, 1'b0} + {18'b0, r_s17_z[30:0]};
            r_s18_d        <= {r_s17_z, 1'b0};
            r_s18_sd.neg_u <= r_s17_nx[48];
            r_s18_sd.neg_v <= r_s17_ny[48];
            r_s18_sd.ovf_u <= 1'b0;
            r_s18_sd.ovf_v <= 1'b0;
            r_s18_sd.fault <= r_s17_flt;
        end
    end

    // restoring divider, one quotient bit per stage
    always_comb begin
        w_sd0       = r_s18_sd;
        w_sd0.ovf_u = ({6'b0, r_s18_nu} >= {r_s18_d, {QUO_W{1'b0}}});
        w_sd0.ovf_v = ({6'b0, r_s18_nv} >= {r_s18_d, {QUO_W{1'b0}}});
        for (int j = 0; j < NDIV; j++) begin
            w_sh_u[j] = {r_rem_u[j], r_low_u[j][QUO_W-1]};
            w_sh_v[j] = {r_rem_v[j], r_low_v[j][QUO_W-1]};
            w_ge_u[j] = (w_sh_u[j] >= {1'b0, r_dd[j]});
            w_ge_v[j] = (w_sh_v[j] >= {1'b0, r_dd[j]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_rem_u[0]    <= {6'b0, r_s18_nu[48:QUO_W]};
            r_rem_v[0]    <= {6'b0, r_s18_nv[48:QUO_W]};
            r_low_u[0]    <= r_s18_nu[QUO_W-1:0];
            r_low_v[0]    <= r_s18_nv[QUO_W-1:0];
            r_quo_u[0]    <= '0;
            r_quo_v[0]    <= '0;
            r_dd[0]       <= r_s18_d;
            r_sd[0]       <= w_sd0;
            for (int j = 1; j < NDIV; j++) begin
                r_rem_u[j] <= w_ge_u[j-1] ? 33'(w_sh_u[j-1] - {1'b0, r_dd[j-1]})
                                          : w_sh_u[j-1][32:0];
                r_rem_v[j] <= w_ge_v[j-1] ? 33'(w_sh_v[j-1] - {1'b0, r_dd[j-1]})
                                          : w_sh_v[j-1][32:0];
                r_low_u[j] <= {r_low_u[j-1][QUO_W-2:0], 1'b0};
                r_low_v[j] <= {r_low_v[j-1][QUO_W-2:0], 1'b0};
                r_quo_u[j] <= {r_quo_u[j-1][QUO_W-2:0], w_ge_u[j-1]};
                r_quo_v[j] <= {r_quo_v[j-1][QUO_W-2:0], w_ge_v[j-1]};
                r_dd[j]    <= r_dd[j-1];
                r_sd[j]    <= r_sd[j-1];
            end
        end
    end

    // sign, principal point, detected pixel, saturation
    always_comb begin
        w_qq_u = r_sd[NDIV-1].ovf_u ? {QUO_W{1'b1}} : r_quo_u[NDIV-1];
        w_qq_v = r_sd[NDIV-1].ovf_v ? {QUO_W{1'b1}} : r_quo_v[NDIV-1];
        w_ru = (r_sd[NDIV-1].neg_u ? -$signed({4'b0, w_qq_u}) : $signed({4'b0, w_qq_u}))
             + $signed({10'b0, r_intr[47:32]}) - $signed({10'b0, r_pu[LAT-1]});
        w_rv = (r_sd[NDIV-1].neg_v ? -$signed({4'b0, w_qq_v}) : $signed({4'b0, w_qq_v}))
             + $signed({10'b0, r_intr[63:48]}) - $signed({10'b0, r_pv[LAT-1]});
        if (w_ru > 26'sd524287) begin
            n_out_u = 20'sd524287;
        end else if (w_ru < -26'sd524288) begin
            n_out_u = -20'sd524288;
        end else begin
            n_out_u = w_ru[19:0];
        end
        if (w_rv > 26'sd524287) begin
            n_out_v = 20'sd524287;
        end else if (w_rv < -26'sd524288) begin
            n_out_v = -20'sd524288;
        end else begin
            n_out_v = w_rv[19:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_f <= r_sd[NDIV-1].fault;
            r_out_u <= r_sd[NDIV-1].fault ? '0 : n_out_u;
            r_out_v <= r_sd[NDIV-1].fault ? '0 : n_out_v;
        end
    end

    assign o_res.valid       = r_v[LAT];
    assign o_res.residual_u  = r_out_u;
    assign o_res.residual_v  = r_out_v;
    assign o_res.depth_fault = r_out_f;

endmodule

`default_nettype wire

// ===== rtl/cprr_checker.sv =====
// port-level checks for the reprojection residual block, bound to the top level
// depends on chained_pose_reprojection_residual_assert.svh
`default_nettype none
`include "chained_pose_reprojection_residual_assert.svh"

module cprr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [19:0] i_res_u,
    input logic [19:0] i_res_v,
    input logic        i_fault
);

    `CPRR_ASSERT_NXT(a_stall_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_res_u) && $stable(i_res_v) && $stable(i_fault),
        "stalled result changed")

    `CPRR_ASSERT_IMP(a_fault_zero, i_clk, i_rst_n, i_out_valid && i_fault,
        i_res_u == 20'd0 && i_res_v == 20'd0, "depth fault with nonzero residual")

    `CPRR_ASSERT_IMP(a_stall_blocks, i_clk, i_rst_n, i_out_valid && !i_out_ready,
        !i_in_ready, "request taken while result stalled")

    `CPRR_ASSERT_IMP(a_drain_ready, i_clk, i_rst_n, !i_out_valid || i_out_ready,
        i_in_ready, "request refused while pipeline can advance")

endmodule

bind chained_pose_reprojection_residual cprr_checker u_cprr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_res_u     (o_res.residual_u),
    .i_res_v     (o_res.residual_v),
    .i_fault     (o_res.depth_fault)
);

`default_nettype wire
